// ===== rtl/modexp_pkg.sv =====
// Shared types for the modular exponentiation unit.
package modexp_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_DBL,
      ST_ADD,
      ST_FINISH
   } state_type;

   localparam int unsigned REG_MODULUS  = 0;
   localparam int unsigned REG_EXPONENT = 1;

endpackage

// ===== rtl/modular_exponentiation_unit.sv =====
// Modular exponentiation: message ^ exponent mod modulus by square-and-multiply.
// The message is first reduced mod modulus bit by bit, then for each of the EXP_WIDTH exponent bits
// one squaring and, for a set bit, one multiplication; a modular multiplication doubles once per
// multiplier bit and adds for each set bit on the shared modular adder. The result is registered
// once the result port is free. One item at a time; the next item is accepted once the result is
// registered, so a result stall also holds off the next item.
// Synchronous active-high reset: modulus = 1, exponent = 0, no item in flight.
module modular_exponentiation_unit #(
   parameter int WIDTH     = 32,
   parameter int EXP_WIDTH = 32,
   localparam int DATA_W   = ((WIDTH + 7) / 8) * 8,
   localparam int CSR_DW   = (WIDTH > 32 || EXP_WIDTH > 32) ? 64 : 32,
   localparam int CSR_AW   = (CSR_DW == 64) ? 4 : 3
) (
   input  logic              clock,
   input  logic              reset,
   // input item
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // [WIDTH-1:0] message
   // result item
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // [WIDTH-1:0] power
   // register port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);
   import modexp_pkg::*;

   localparam int CW  = (WIDTH > 1) ? $clog2(WIDTH) : 1;
   localparam int EW  = (EXP_WIDTH > 1) ? $clog2(EXP_WIDTH) : 1;
   localparam int ASH = (CSR_DW == 64) ? 3 : 2;

   state_type state_ff, state_in;

   logic [WIDTH-1:0]     modulus_ff, modulus_in;
   logic [EXP_WIDTH-1:0] exponent_ff, exponent_in;
   logic [WIDTH-1:0]     msg_ff, msg_in;
   logic [WIDTH-1:0]     base_ff, base_in;
   logic [WIDTH-1:0]     acc_ff, acc_in;
   logic [WIDTH-1:0]     prod_ff, prod_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [EW-1:0]        ebit_ff, ebit_in;
   logic                 sq_ff, sq_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0]     power_ff, power_in;

   // shared modular adder: (a + b + cin) mod n, for a < n and b < n
   logic [WIDTH-1:0] op_a, op_b;
   logic             op_cin;
   logic [WIDTH:0]   sum, diff;
   logic [WIDTH-1:0] unit_res;

   logic req_acc, rsp_free, last_bit, bbit, mult_done, do_mul, exp_done;
   logic csr_wr;
   logic [CSR_AW-ASH-1:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_AW-1:ASH];

   always_comb begin
      csr_prdata = '0;
      case (csr_idx)
         (CSR_AW-ASH)'(REG_MODULUS):  csr_prdata = CSR_DW'(modulus_ff);
         (CSR_AW-ASH)'(REG_EXPONENT): csr_prdata = CSR_DW'(exponent_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   always_comb begin
      modulus_in  = modulus_ff;
      exponent_in = exponent_ff;
      if (csr_wr && csr_idx == (CSR_AW-ASH)'(REG_MODULUS)) begin
         modulus_in = csr_pwdata[WIDTH-1:0];
      end
      if (csr_wr && csr_idx == (CSR_AW-ASH)'(REG_EXPONENT)) begin
         exponent_in = csr_pwdata[EXP_WIDTH-1:0];
      end
   end

   always_comb begin
      op_a   = '0;
      op_b   = '0;
      op_cin = 1'b0;
      case (state_ff)
         ST_REDUCE: begin
            op_a   = prod_ff;
            op_b   = prod_ff;
            op_cin = msg_ff[cnt_ff];
         end
         ST_DBL: begin
            op_a = prod_ff;
            op_b = prod_ff;
         end
         ST_ADD: begin
            op_a = prod_ff;
            op_b = sq_ff ? acc_ff : base_ff;
         end
         default: begin
            op_a = '0;
         end
      endcase
      sum      = {1'b0, op_a} + {1'b0, op_b} + (WIDTH+1)'(op_cin);
      diff     = sum - {1'b0, modulus_ff};
      unit_res = (sum >= {1'b0, modulus_ff}) ? diff[WIDTH-1:0] : sum[WIDTH-1:0];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;
   assign last_bit   = (cnt_ff == '0);
   assign bbit       = acc_ff[cnt_ff];
   // a multiplication ends on its last bit, after the add if that bit is set
   assign mult_done  = last_bit & ((state_ff == ST_ADD) | ((state_ff == ST_DBL) & ~bbit));
   assign do_mul     = sq_ff & exponent_ff[ebit_ff];
   assign exp_done   = (ebit_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = (modulus_ff == '0) ? ST_FINISH : ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (last_bit) state_in = ST_DBL;
         end
         ST_DBL: begin
            if (bbit) begin
               state_in = ST_ADD;
            end else if (mult_done && !do_mul && exp_done) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DBL;
            end
         end
         ST_ADD: begin
            if (mult_done && !do_mul && exp_done) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DBL;
            end
         end
         ST_FINISH: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      msg_in       = msg_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      cnt_in       = cnt_ff;
      ebit_in      = ebit_ff;
      sq_in        = sq_ff;
      power_in     = power_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               msg_in  = req_tdata[WIDTH-1:0];
               prod_in = '0;
               acc_in  = '0;
               cnt_in  = CW'(WIDTH - 1);
            end
         end
         ST_REDUCE: begin
            prod_in = unit_res;
            cnt_in  = cnt_ff - CW'(1);
            if (last_bit) begin
               base_in = unit_res;
               acc_in  = (modulus_ff == WIDTH'(1)) ? '0 : WIDTH'(1);
               prod_in = '0;
               cnt_in  = CW'(WIDTH - 1);
               ebit_in = EW'(EXP_WIDTH - 1);
               sq_in   = 1'b1;
            end
         end
         ST_DBL, ST_ADD: begin
            prod_in = unit_res;
            if (state_ff == ST_ADD || !bbit) begin
               cnt_in = cnt_ff - CW'(1);
            end
            if (mult_done) begin
               acc_in  = unit_res;
               prod_in = '0;
               cnt_in  = CW'(WIDTH - 1);
               if (do_mul) begin
                  sq_in = 1'b0;
               end else begin
                  sq_in   = 1'b1;
                  ebit_in = ebit_ff - EW'(1);
               end
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               power_in     = acc_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            prod_in = prod_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         modulus_ff   <= WIDTH'(1);
         exponent_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         exponent_ff  <= exponent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      msg_ff   <= msg_in;
      base_ff  <= base_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      cnt_ff   <= cnt_in;
      ebit_ff  <= ebit_in;
      sq_ff    <= sq_in;
      power_ff <= power_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(power_ff);

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the modular exponentiation unit: stream driver, monitor, scoreboard.
module tb_top;
   import modexp_pkg::*;

   localparam logic [2:0] MODULUS_ADDR  = 3'(4 * REG_MODULUS);
   localparam logic [2:0] EXPONENT_ADDR = 3'(4 * REG_EXPONENT);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;     // [31:0] message
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [31:0] power
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic [31:0] message_queue[$];   // messages waiting to be driven
   logic [31:0] power_due[$];       // predicted powers, oldest first
   logic [31:0] key_modulus;
   logic [31:0] key_exponent;
   bit          calm = 1'b0;
   int          send_gap = 0;
   int          hold_left = 0;
   int unsigned errors = 0;
   int unsigned messages_sent = 0;
   int unsigned powers_checked = 0;
   int unsigned key_settings = 0;

   modular_exponentiation_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Square-and-multiply over all 32 exponent bits, most significant first.
   function automatic logic [31:0] modpow(logic [31:0] base, logic [31:0] n,
                                          logic [31:0] e);
      logic [63:0] acc;
      logic [63:0] b;
      if (n == 0) return '0;
      b = base % n;
      acc = 64'd1 % n;
      for (int i = 31; i >= 0; i--) begin
         acc = (acc * acc) % n;
         if (e[i]) acc = (acc * b) % n;
      end
      return acc[31:0];
   endfunction

   // Message driver with random idle bursts between items.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (message_queue.size() != 0) begin
            req_tdata <= message_queue.pop_front();
            req_tvalid <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 14);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result backpressure in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
         hold_left <= $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Track register writes, predict on each accepted message, check each power.
   always @(posedge clock) begin
      if (reset) begin
         key_modulus <= 32'd1;
         key_exponent <= '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == MODULUS_ADDR) key_modulus <= csr_pwdata;
            else if (csr_paddr == EXPONENT_ADDR) key_exponent <= csr_pwdata;
         end
         if (req_tvalid && req_tready) begin
            power_due.push_back(modpow(req_tdata, key_modulus, key_exponent));
            messages_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (power_due.size() == 0) begin
               errors++;
               if (errors <= 20)
                  $display("%0t: unexpected power, expected none, got %h", $time, rsp_tdata);
            end else begin
               logic [31:0] want;
               want = power_due.pop_front();
               powers_checked++;
               if (rsp_tdata !== want) begin
                  errors++;
                  if (errors <= 20)
                     $display("%0t: power mismatch, expected %h, got %h",
                              $time, want, rsp_tdata);
               end
            end
         end
      end
   end

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic csr_read(input logic [2:0] addr, output logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      value = csr_prdata;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Hold until every message is out and every power is back.
   task automatic settle();
      @(negedge clock);
      while (message_queue.size() != 0 || power_due.size() != 0 || req_tvalid)
         @(negedge clock);
   endtask

   task automatic set_keys(input logic [31:0] n, input logic [31:0] e);
      logic [31:0] got;
      settle();
      csr_write(MODULUS_ADDR, n);
      csr_write(EXPONENT_ADDR, e);
      csr_read(MODULUS_ADDR, got);
      if (got !== n) begin
         errors++;
         $display("%0t: modulus readback, expected %h, got %h", $time, n, got);
      end
      csr_read(EXPONENT_ADDR, got);
      if (got !== e) begin
         errors++;
         $display("%0t: exponent readback, expected %h, got %h", $time, e, got);
      end
      key_settings++;
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_modulus();
      logic [31:0] n;
      case ($urandom_range(0, 9))
         0: n = 32'd1;
         1: n = 32'd2;
         2: n = 32'hFFFF_FFFF;
         3: n = $urandom_range(3, 255);
         4: n = $urandom_range(256, 65535);
         default: n = $urandom;
      endcase
      return (n == 0) ? 32'd1 : n;
   endfunction

   function automatic logic [31:0] pick_exponent();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(1, 64);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_message(logic [31:0] n);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 32'hFFFF_FFFF;
         2: return n - 1;
         3: return n;
         4: return n + 1;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset keys: modulus one gives zero.
      message_queue.push_back(32'h0);
      message_queue.push_back(32'hFFFF_FFFF);
      // Exponent zero gives one.
      set_keys(32'hFFFF_FFFF, 32'h0);
      message_queue.push_back(32'h0);
      message_queue.push_back(32'hFFFF_FFFF);
      message_queue.push_back(32'h1234_5678);
      set_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      message_queue.push_back(32'h0);
      message_queue.push_back(32'h1);
      message_queue.push_back(32'h2);
      message_queue.push_back(32'hFFFF_FFFE);
      message_queue.push_back(32'hFFFF_FFFF);
      message_queue.push_back(32'h8000_0000);
      set_keys(32'd1, 32'hFFFF_FFFF);
      message_queue.push_back(32'h1234_5678);
      set_keys(32'd2, 32'd1);
      message_queue.push_back(32'd3);
      message_queue.push_back(32'd4);
      set_keys(32'hFFFF_FFFB, 32'hFFFF_FFFA);
      message_queue.push_back(32'd5);
      message_queue.push_back(32'hDEAD_BEEF);
      // Small textbook key pair: encrypt, then decrypt.
      set_keys(32'd3233, 32'd17);
      message_queue.push_back(32'd65);
      set_keys(32'd3233, 32'd2753);
      message_queue.push_back(32'd2790);
      message_queue.push_back(32'd65);

      for (int p = 0; p < 9; p++) begin
         n = pick_modulus();
         set_keys(n, pick_exponent());
         if (p == 8) calm = 1'b1;
         for (int k = 0; k < 30; k++) message_queue.push_back(pick_message(n));
      end

      settle();
      repeat (50) @(posedge clock);
      $display("run: %0d messages driven, %0d powers checked over %0d key settings",
               messages_sent, powers_checked, key_settings);
      $display("run: moduli at 1, 2 and all ones, exponents at zero and all ones, random keys");
      if (errors == 0 && power_due.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
